// ----- hw/rtl/value_noise_turbulence_sampler_macros.svh -----
// assertion macros for the value noise turbulence sampler checker
// no dependencies; taken in by the checker file with include
`ifndef VALUE_NOISE_TURBULENCE_SAMPLER_MACROS_SVH
`define VALUE_NOISE_TURBULENCE_SAMPLER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define VNTS_ASSERT_IMPLY(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("vnts check failed");

// next-cycle implication, disabled while reset is high
`define VNTS_ASSERT_NEXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("vnts check failed");

`endif

// ----- hw/rtl/vnts_pkg.sv -----
// shared types and constants of the value noise turbulence sampler
// used by the divider, the top level and the checker; no dependencies
package vnts_pkg;

  // default parameter values
  localparam int MAX_DIM_DEF   = 256;
  localparam int FRAC_BITS_DEF = 8;

  // fixed field widths
  localparam int POS_W   = 8;
  localparam int TEXEL_W = 8;
  localparam int DIM_W   = 9;
  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 5;
  localparam int PIX_W   = 8;

  // divider: divisor and remainder width, step counter width
  localparam int DIV_W  = 16;
  localparam int STEP_W = 6;

  // integer part of the octave sum is below 256 times sixteen
  localparam int AVG_W = PIX_W + 4;

  // register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register reset values
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 9'd256;
  localparam logic [SIZE_W-1:0] SIZE_RST   = 16'd4096;

  // register indexes, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TURB_SIZE    = 2'd2
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_MOD_X,
    ST_MOD_Y,
    ST_WR,
    ST_RD,
    ST_MAC,
    ST_AVG,
    ST_OUT
  } state_t;

  // divider control and status
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hw/rtl/vnts_div.sv -----
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on vnts_pkg; the dividend is aligned to its top bits by the caller
module vnts_div #(
  parameter int DW = vnts_pkg::POS_W + 2 * vnts_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  vnts_pkg::div_ctrl_t        ctrl,
  input  logic [DW-1:0]              dividend,
  input  logic [vnts_pkg::DIV_W-1:0] divisor,
  output vnts_pkg::div_stat_t        stat,
  output logic [DW-1:0]              quotient,
  output logic [vnts_pkg::DIV_W-1:0] remainder
);

  logic [vnts_pkg::STEP_W-1:0] cnt;
  logic                        done;
  logic [DW-1:0]               quo;
  logic [vnts_pkg::DIV_W-1:0]  rem;
  logic [vnts_pkg::DIV_W-1:0]  dvs;

  logic [vnts_pkg::DIV_W:0]    rem_sh;
  logic [vnts_pkg::DIV_W:0]    diff;
  logic                        ge;
  logic [vnts_pkg::DIV_W-1:0]  rem_step;
  logic [DW-1:0]               quo_step;

  // one shift and trial subtract
  always_comb begin
    rem_sh   = {rem, quo[DW-1]};
    ge       = (rem_sh >= {1'b0, dvs});
    diff     = rem_sh - {1'b0, dvs};
    rem_step = ge ? diff[vnts_pkg::DIV_W-1:0] : rem_sh[vnts_pkg::DIV_W-1:0];
    quo_step = {quo[DW-2:0], ge};
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        cnt <= ctrl.steps;
      end else if (cnt != '0) begin
        cnt  <= cnt - vnts_pkg::STEP_W'(1);
        done <= (cnt == vnts_pkg::STEP_W'(1));
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= quo_step;
      rem <= rem_step;
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- hw/rtl/value_noise_turbulence_sampler.sv -----
// value noise turbulence sampler: noise image store and octave sequencer
// depends on vnts_pkg and vnts_div
//
// Usage
//   Request channel (cmd_valid, cmd_stall, command, pos_x, pos_y, texel):
//   command 0 writes texel into the noise image at (pos_x, pos_y), command 1
//   computes turbulence at pixel (pos_x, pos_y). Only compute requests give a
//   result on (res_valid, res_stall, pixel_value, octave_count, no_octave).
//   One request is worked on at a time; cmd_stall is high until it is done.
//   Every division runs through one shared radix-2 divider, one bit per cycle.
//   A load takes two modulo divisions and a write. Each octave of a compute
//   takes two divisions of 8 + 2F bits by the size (F = 8 fraction bits), two
//   modulo divisions and four corner reads; an averaging division and the
//   output follow. A starting size below one goes straight to the output.
//   The result sits in an output register; while the receiver stalls a
//   further request still runs, and only its final hand-over waits.
//   Registers (APB, byte address 4 * index): image_width, image_height,
//   turbulence_size; write them only while the block is idle.
//   Reset clears the control state and restores the register defaults; the
//   noise image is not cleared, so load every texel before it is sampled.
module value_noise_turbulence_sampler #(
  parameter int MAX_DIM   = vnts_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = vnts_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic                         command,
  input  logic [vnts_pkg::POS_W-1:0]   pos_x,
  input  logic [vnts_pkg::POS_W-1:0]   pos_y,
  input  logic [vnts_pkg::TEXEL_W-1:0] texel,
  // result channel
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [vnts_pkg::PIX_W-1:0]   pixel_value,
  output logic [vnts_pkg::COUNT_W-1:0] octave_count,
  output logic                         no_octave,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vnts_pkg::PADDR_W-1:0] paddr,
  input  logic [vnts_pkg::PDATA_W-1:0] pwdata,
  output logic [vnts_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int DW    = vnts_pkg::POS_W + 2 * FRAC_BITS;
  localparam int CW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int WT_W  = FRAC_BITS + 1;
  localparam int WP_W  = 2 * WT_W;
  localparam int MP_W  = WP_W + vnts_pkg::TEXEL_W;
  localparam int SUM_W = 2 * FRAC_BITS + vnts_pkg::AVG_W;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int SZ_W  = vnts_pkg::SIZE_W;
  localparam int DV_W  = vnts_pkg::DIV_W;

  // configuration registers
  logic [vnts_pkg::DIM_W-1:0] image_width;
  logic [vnts_pkg::DIM_W-1:0] image_height;
  logic [SZ_W-1:0]            turbulence_size;

  // sequencer
  vnts_pkg::state_t state, state_next;

  // per-request registers
  logic                           is_load;
  logic [vnts_pkg::POS_W-1:0]     px;
  logic [vnts_pkg::POS_W-1:0]     py;
  logic [vnts_pkg::TEXEL_W-1:0]   tex;
  logic [SZ_W-1:0]                size;
  logic [DV_W-1:0]                mod_x;
  logic [DV_W-1:0]                mod_y;
  logic [FRAC_BITS-1:0]           fx;
  logic [FRAC_BITS-1:0]           fy;
  logic [vnts_pkg::POS_W-1:0]     ix;
  logic [vnts_pkg::POS_W-1:0]     iy;
  logic [CW-1:0]                  x1;
  logic [CW-1:0]                  y1;
  logic [1:0]                     corner;
  logic [WP_W-1:0]                wprod;
  logic [vnts_pkg::TEXEL_W-1:0]   rdata;
  logic [SUM_W-1:0]               sum;
  logic [vnts_pkg::COUNT_W-1:0]   count;

  // noise image
  logic [vnts_pkg::TEXEL_W-1:0] mem [DEPTH];

  // divider hookup
  vnts_pkg::div_ctrl_t div_ctrl;
  vnts_pkg::div_stat_t div_stat;
  logic [DW-1:0]       div_dividend;
  logic [DV_W-1:0]     div_divisor;
  logic [DW-1:0]       div_quo;
  logic [DV_W-1:0]     div_rem;

  // combinational helpers
  logic                 accept;
  logic                 cfg_we;
  vnts_pkg::reg_idx_t   cfg_idx;
  logic [DV_W-1:0]      w_ext;
  logic [DV_W-1:0]      h_ext;
  logic [DV_W-1:0]      w_eff;
  logic [DV_W-1:0]      h_eff;
  logic                 start_small;
  logic                 more_octaves;
  logic                 div_state;
  logic [DV_W-1:0]      mod_x_m1;
  logic [DV_W-1:0]      mod_y_m1;
  logic [CW-1:0]        x2;
  logic [CW-1:0]        y2;
  logic [CW-1:0]        col;
  logic [CW-1:0]        row;
  logic [AW-1:0]        addr;
  logic [WT_W-1:0]      gx;
  logic [WT_W-1:0]      gy;
  logic [WT_W-1:0]      wa;
  logic [WT_W-1:0]      wb;
  logic [MP_W-1:0]      mprod;
  logic                 mem_we;
  logic                 out_load;

  // register port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = vnts_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= vnts_pkg::WIDTH_RST;
      image_height    <= vnts_pkg::HEIGHT_RST;
      turbulence_size <= vnts_pkg::SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        vnts_pkg::REG_IMAGE_WIDTH:  image_width     <= pwdata[vnts_pkg::DIM_W-1:0];
        vnts_pkg::REG_IMAGE_HEIGHT: image_height    <= pwdata[vnts_pkg::DIM_W-1:0];
        vnts_pkg::REG_TURB_SIZE:    turbulence_size <= pwdata[SZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vnts_pkg::REG_IMAGE_WIDTH:  prdata = vnts_pkg::PDATA_W'(image_width);
      vnts_pkg::REG_IMAGE_HEIGHT: prdata = vnts_pkg::PDATA_W'(image_height);
      vnts_pkg::REG_TURB_SIZE:    prdata = vnts_pkg::PDATA_W'(turbulence_size);
      default:                    prdata = '0;
    endcase
  end

  // wrap moduli clamped to 1..MAX_DIM
  always_comb begin
    w_ext = DV_W'(image_width);
    h_ext = DV_W'(image_height);
    if (w_ext == '0) begin
      w_eff = DV_W'(1);
    end else if (w_ext > DV_W'(MAX_DIM)) begin
      w_eff = DV_W'(MAX_DIM);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = DV_W'(1);
    end else if (h_ext > DV_W'(MAX_DIM)) begin
      h_eff = DV_W'(MAX_DIM);
    end else begin
      h_eff = h_ext;
    end
  end

  // size tests against 1.0, one bit wider so any fraction width fits
  assign start_small  = ({1'b0, turbulence_size} < (SZ_W + 1)'(ONE));
  assign more_octaves = ({2'b0, size[SZ_W-1:1]} >= (SZ_W + 1)'(ONE));

  assign cmd_stall = (state != vnts_pkg::ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign div_state = (state inside {vnts_pkg::ST_DIV_X, vnts_pkg::ST_DIV_Y,
                                    vnts_pkg::ST_MOD_X, vnts_pkg::ST_MOD_Y,
                                    vnts_pkg::ST_AVG});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vnts_pkg::ST_IDLE: begin
        if (accept) begin
          if (!command) begin
            state_next = vnts_pkg::ST_MOD_X;
          end else if (start_small) begin
            state_next = vnts_pkg::ST_OUT;
          end else begin
            state_next = vnts_pkg::ST_DIV_X;
          end
        end
      end
      vnts_pkg::ST_DIV_X: if (div_stat.done) state_next = vnts_pkg::ST_DIV_Y;
      vnts_pkg::ST_DIV_Y: if (div_stat.done) state_next = vnts_pkg::ST_MOD_X;
      vnts_pkg::ST_MOD_X: if (div_stat.done) state_next = vnts_pkg::ST_MOD_Y;
      vnts_pkg::ST_MOD_Y: begin
        if (div_stat.done) begin
          state_next = is_load ? vnts_pkg::ST_WR : vnts_pkg::ST_RD;
        end
      end
      vnts_pkg::ST_WR: state_next = vnts_pkg::ST_IDLE;
      vnts_pkg::ST_RD: state_next = vnts_pkg::ST_MAC;
      vnts_pkg::ST_MAC: begin
        if (corner != 2'd3) begin
          state_next = vnts_pkg::ST_RD;
        end else if (more_octaves) begin
          state_next = vnts_pkg::ST_DIV_X;
        end else begin
          state_next = vnts_pkg::ST_AVG;
        end
      end
      vnts_pkg::ST_AVG: if (div_stat.done) state_next = vnts_pkg::ST_OUT;
      vnts_pkg::ST_OUT: begin
        if (!res_valid || !res_stall) state_next = vnts_pkg::ST_IDLE;
      end
      default: state_next = vnts_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: divider request, memory write, result load
  always_comb begin
    div_ctrl.start = div_state && !div_stat.busy && !div_stat.done;
    div_ctrl.steps = vnts_pkg::STEP_W'(vnts_pkg::POS_W);
    div_dividend   = {ix, {(DW - vnts_pkg::POS_W){1'b0}}};
    div_divisor    = mod_x;
    case (state)
      vnts_pkg::ST_DIV_X: begin
        div_ctrl.steps = vnts_pkg::STEP_W'(DW);
        div_dividend   = {px, {(2 * FRAC_BITS){1'b0}}};
        div_divisor    = DV_W'(size);
      end
      vnts_pkg::ST_DIV_Y: begin
        div_ctrl.steps = vnts_pkg::STEP_W'(DW);
        div_dividend   = {py, {(2 * FRAC_BITS){1'b0}}};
        div_divisor    = DV_W'(size);
      end
      vnts_pkg::ST_MOD_Y: begin
        div_dividend = {iy, {(DW - vnts_pkg::POS_W){1'b0}}};
        div_divisor  = mod_y;
      end
      vnts_pkg::ST_AVG: begin
        div_ctrl.steps = vnts_pkg::STEP_W'(vnts_pkg::AVG_W);
        div_dividend   = {sum[SUM_W-1 -: vnts_pkg::AVG_W],
                          {(DW - vnts_pkg::AVG_W){1'b0}}};
        div_divisor    = DV_W'(count);
      end
      default: ;
    endcase
    mem_we   = (state == vnts_pkg::ST_WR);
    out_load = (state == vnts_pkg::ST_OUT) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vnts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  vnts_div #(
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // neighbor cells with wraparound
  always_comb begin
    mod_x_m1 = mod_x - DV_W'(1);
    mod_y_m1 = mod_y - DV_W'(1);
    x2  = (x1 == '0) ? mod_x_m1[CW-1:0] : x1 - CW'(1);
    y2  = (y1 == '0) ? mod_y_m1[CW-1:0] : y1 - CW'(1);
    col = corner[0] ? x2 : x1;
    row = corner[1] ? y2 : y1;
    addr = AW'(row) * AW'(MAX_DIM) + AW'(col);
  end

  // bilinear weights for the current corner
  always_comb begin
    gx    = WT_W'(ONE) - WT_W'(fx);
    gy    = WT_W'(ONE) - WT_W'(fy);
    wa    = corner[0] ? gx : WT_W'(fx);
    wb    = corner[1] ? gy : WT_W'(fy);
    mprod = MP_W'(wprod) * MP_W'(rdata);
  end

  // noise image port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= tex;
    end
    rdata <= mem[addr];
  end

  // request registers and octave datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      is_load <= !command;
      px      <= pos_x;
      py      <= pos_y;
      tex     <= texel;
      ix      <= pos_x;
      iy      <= pos_y;
      size    <= turbulence_size;
      mod_x   <= command ? w_eff : DV_W'(MAX_DIM);
      mod_y   <= command ? h_eff : DV_W'(MAX_DIM);
      sum     <= '0;
      count   <= '0;
      corner  <= 2'd0;
    end
    if (div_stat.done) begin
      case (state)
        vnts_pkg::ST_DIV_X: begin
          fx <= div_quo[FRAC_BITS-1:0];
          ix <= div_quo[FRAC_BITS +: vnts_pkg::POS_W];
        end
        vnts_pkg::ST_DIV_Y: begin
          fy <= div_quo[FRAC_BITS-1:0];
          iy <= div_quo[FRAC_BITS +: vnts_pkg::POS_W];
        end
        vnts_pkg::ST_MOD_X: x1 <= div_rem[CW-1:0];
        vnts_pkg::ST_MOD_Y: y1 <= div_rem[CW-1:0];
        default: ;
      endcase
    end
    if (state == vnts_pkg::ST_RD) begin
      wprod <= WP_W'(wa) * WP_W'(wb);
    end
    if (state == vnts_pkg::ST_MAC) begin
      sum    <= sum + SUM_W'(mprod);
      corner <= corner + 2'd1;
      if (corner == 2'd3) begin
        size  <= size >> 1;
        count <= count + vnts_pkg::COUNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_value  <= (count == '0) ? '0 : div_quo[vnts_pkg::PIX_W-1:0];
      octave_count <= count;
      no_octave    <= (count == '0);
    end
  end

endmodule

// ----- hw/rtl/vnts_checker.sv -----
// port-level checks for the value noise turbulence sampler, bound to the top
// depends on vnts_pkg and the assertion macro header
`include "value_noise_turbulence_sampler_macros.svh"

module vnts_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_stall,
  input logic                         res_valid,
  input logic                         res_stall,
  input logic [vnts_pkg::PIX_W-1:0]   pixel_value,
  input logic [vnts_pkg::COUNT_W-1:0] octave_count,
  input logic                         no_octave
);

  // a stalled result holds
  `VNTS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(pixel_value) && $stable(octave_count) && $stable(no_octave))

  // an accepted request keeps the block busy in the next cycle
  `VNTS_ASSERT_NEXT(a_busy_after_req, clk, rst, cmd_valid && !cmd_stall, cmd_stall)

  // a result without octaves is all zero
  `VNTS_ASSERT_IMPLY(a_no_octave_zero, clk, rst, res_valid && no_octave, pixel_value == '0 && octave_count == '0)

  // a result with octaves counts at least one
  `VNTS_ASSERT_IMPLY(a_octave_nonzero, clk, rst, res_valid && !no_octave, octave_count != '0)

endmodule

bind value_noise_turbulence_sampler vnts_checker u_vnts_checker (.*);

// ----- tb/value_noise_turbulence_sampler_tb.sv -----
// self-checking testbench for the value noise turbulence sampler: texel loads,
// turbulence requests and register writes, with predicted results checked field by field
// depends on vnts_pkg and the value_noise_turbulence_sampler rtl
module value_noise_turbulence_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vnts_pkg::*;

  localparam int          DIM  = MAX_DIM_DEF;
  localparam int          FRAC = FRAC_BITS_DEF;
  localparam int unsigned ONE  = 1 << FRAC;

  // request opcodes and the register slot past the end of the map
  localparam logic       CMD_LOAD      = 1'b0;
  localparam logic       CMD_COMPUTE   = 1'b1;
  localparam logic [1:0] REG_SPARE_IDX = 2'd3;

  localparam int PHASE_REQS = 215;
  localparam int NUM_PHASES = 8;
  localparam int SETTLE_CYC = 40;

  typedef struct packed {
    logic               cmd;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [TEXEL_W-1:0] t;
  } noise_req_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COUNT_W-1:0] count;
    logic               flag;
  } turb_res_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SOME,
    STALL_HEAVY
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  logic                 command;
  logic [POS_W-1:0]     pos_x;
  logic [POS_W-1:0]     pos_y;
  logic [TEXEL_W-1:0]   texel;
  logic                 res_valid;
  logic                 res_stall;
  logic [PIX_W-1:0]     pixel_value;
  logic [COUNT_W-1:0]   octave_count;
  logic                 no_octave;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // shadow registers and noise image as the predictor sees them
  logic [DIM_W-1:0]     cfg_width  = WIDTH_RST;
  logic [DIM_W-1:0]     cfg_height = HEIGHT_RST;
  logic [SIZE_W-1:0]    cfg_size   = SIZE_RST;
  logic [TEXEL_W-1:0]   noise_img [0:DIM*DIM-1];
  // texels that some queued load already covers
  bit                   cell_loaded [0:DIM*DIM-1];

  noise_req_t           pending_reqs [$];
  turb_res_t            expected_pixels [$];
  int                   items_queued = 0;
  int                   items_taken  = 0;
  int                   err_count    = 0;
  logic                 req_accepted = 1'b0;
  int                   burst_left   = 1;
  int                   gap_left     = 0;
  stall_mode_t          stall_mode   = STALL_NONE;
  int                   stall_left   = 0;

  value_noise_turbulence_sampler uut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .texel        (texel),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .pixel_value  (pixel_value),
    .octave_count (octave_count),
    .no_octave    (no_octave),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // zero acts as one, anything past the store acts as the store size
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d);
    if (d < 1) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  // cell, wrapped neighbours and blend fractions for one octave
  function automatic void octave_cell(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                      input int unsigned size, input int unsigned w,
                                      input int unsigned h, output int unsigned x1,
                                      output int unsigned x2, output int unsigned y1,
                                      output int unsigned y2, output int unsigned fx,
                                      output int unsigned fy);
    int unsigned qx;
    int unsigned qy;
    qx = (32'(x) << (2 * FRAC)) / size;
    qy = (32'(y) << (2 * FRAC)) / size;
    fx = qx & (ONE - 1);
    fy = qy & (ONE - 1);
    x1 = (qx >> FRAC) % w;
    y1 = (qy >> FRAC) % h;
    x2 = (x1 + w - 1) % w;
    y2 = (y1 + h - 1) % h;
  endfunction

  // octave sum averaged over the octave count
  function automatic turb_res_t predict_turbulence(input logic [POS_W-1:0] px,
                                                   input logic [POS_W-1:0] py);
    turb_res_t       r;
    int unsigned     w, h, size, cnt, x1, x2, y1, y2, fx, fy, gx, gy;
    longint unsigned sum;
    w    = clamp_dim(cfg_width);
    h    = clamp_dim(cfg_height);
    size = cfg_size;
    cnt  = 0;
    sum  = 0;
    while (size >= ONE) begin
      octave_cell(px, py, size, w, h, x1, x2, y1, y2, fx, fy);
      gx = ONE - fx;
      gy = ONE - fy;
      sum += longint'(fx * fy * noise_img[y1 * DIM + x1]);
      sum += longint'(gx * fy * noise_img[y1 * DIM + x2]);
      sum += longint'(fx * gy * noise_img[y2 * DIM + x1]);
      sum += longint'(gx * gy * noise_img[y2 * DIM + x2]);
      size >>= 1;
      cnt++;
    end
    if (cnt == 0) begin
      r = '{pixel: '0, count: '0, flag: 1'b1};
    end else begin
      r.pixel = PIX_W'(sum / (longint'(cnt) << (2 * FRAC)));
      r.count = COUNT_W'(cnt);
      r.flag  = 1'b0;
    end
    return r;
  endfunction

  task automatic push_req(input logic cmd, input int unsigned x, input int unsigned y,
                          input int unsigned t);
    noise_req_t r;
    r = '{cmd: cmd, x: POS_W'(x), y: POS_W'(y), t: TEXEL_W'(t)};
    if (cmd == CMD_LOAD) cell_loaded[r.y * DIM + r.x] = 1'b1;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  // load a random texel wherever the cell has never been written
  task automatic fill_cell(input int unsigned x, input int unsigned y);
    if (!cell_loaded[y * DIM + x]) push_req(CMD_LOAD, x, y, $urandom_range(0, 255));
  endtask

  // turbulence request, preceded by loads for every texel it will read
  task automatic push_compute(input int unsigned px, input int unsigned py);
    int unsigned w, h, size, x1, x2, y1, y2, fx, fy;
    w    = clamp_dim(cfg_width);
    h    = clamp_dim(cfg_height);
    size = cfg_size;
    while (size >= ONE) begin
      octave_cell(POS_W'(px), POS_W'(py), size, w, h, x1, x2, y1, y2, fx, fy);
      fill_cell(x1, y1);
      fill_cell(x2, y1);
      fill_cell(x1, y2);
      fill_cell(x2, y2);
      size >>= 1;
    end
    push_req(CMD_COMPUTE, px, py, $urandom_range(0, 255));
  endtask

  // apb write: setup then access
  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  cfg_width  = data[DIM_W-1:0];
      REG_IMAGE_HEIGHT: cfg_height = data[DIM_W-1:0];
      REG_TURB_SIZE:    cfg_size   = data[SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // apb read checked against the shadow value
  task automatic reg_check(input logic [1:0] idx, input logic [PDATA_W-1:0] want,
                           input string what);
    logic [PDATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got !== want) report_mismatch(what, got, want);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // hold new requests until all are taken and every result is back, then let a load finish
  task automatic wait_quiet();
    @(negedge clk);
    while (items_taken != items_queued || expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // reprogram all three registers on an idle block and read them back
  task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned s);
    logic [PDATA_W-1:0] junk;
    wait_quiet();
    junk = $urandom;
    reg_write(REG_IMAGE_WIDTH, {junk[PDATA_W-1:DIM_W], DIM_W'(w)});
    junk = $urandom;
    reg_write(REG_IMAGE_HEIGHT, {junk[PDATA_W-1:DIM_W], DIM_W'(h)});
    junk = $urandom;
    reg_write(REG_TURB_SIZE, {junk[PDATA_W-1:SIZE_W], SIZE_W'(s)});
    reg_check(REG_IMAGE_WIDTH, PDATA_W'(cfg_width), "image_width readback");
    reg_check(REG_IMAGE_HEIGHT, PDATA_W'(cfg_height), "image_height readback");
    reg_check(REG_TURB_SIZE, PDATA_W'(cfg_size), "turbulence_size readback");
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return DIM;
      2:       return 0;
      3:       return $urandom_range(DIM + 1, 511);
      4:       return $urandom_range(2, 16);
      default: return $urandom_range(1, DIM);
    endcase
  endfunction

  // mostly few octaves, sometimes none, now and then the deepest ones
  function automatic int unsigned pick_size();
    case ($urandom_range(0, 6))
      0:       return $urandom_range(0, ONE - 1);
      1:       return $urandom_range(ONE, 4 * ONE - 1);
      2:       return $urandom_range(4 * ONE, 32 * ONE - 1);
      3:       return 65535;
      default: return $urandom_range(ONE, 64 * ONE - 1);
    endcase
  endfunction

  function automatic int unsigned pick_pos();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // request driver: bursts with random gaps, payload held while stalled
  always @(negedge clk) begin : drive_requests
    noise_req_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || req_accepted) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        cmd_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        nxt = pending_reqs.pop_front();
        cmd_valid <= 1'b1;
        command   <= nxt.cmd;
        pos_x     <= nxt.x;
        pos_y     <= nxt.y;
        texel     <= nxt.t;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // result stall pattern: runs of no stall, light stall and heavy stall
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(4, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  res_stall <= 1'b0;
      STALL_SOME:  res_stall <= ($urandom_range(0, 1) == 0);
      default:     res_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // monitor: check results against the oldest expectation, predict on each request
  always @(posedge clk) begin : watch_block
    turb_res_t want;
    if (rst) begin
      req_accepted <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with nothing pending, pixel_value", pixel_value, -1);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_value !== want.pixel) report_mismatch("pixel_value", pixel_value, want.pixel);
          if (octave_count !== want.count)
            report_mismatch("octave_count", octave_count, want.count);
          if (no_octave !== want.flag) report_mismatch("no_octave", no_octave, want.flag);
        end
      end
      req_accepted <= cmd_valid && !cmd_stall;
      if (cmd_valid && !cmd_stall) begin
        items_taken++;
        if (command == CMD_LOAD) noise_img[(pos_y % DIM) * DIM + (pos_x % DIM)] = texel;
        else expected_pixels.push_back(predict_turbulence(pos_x, pos_y));
      end
    end
  end

  // stimulus and end of run
  initial begin
    int phase_start;
    int r;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    command   = CMD_LOAD;
    pos_x     = '0;
    pos_y     = '0;
    texel     = '0;
    res_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: corner texels at both extremes, sample at the origin
    push_req(CMD_LOAD, 0, 0, 255);
    push_req(CMD_LOAD, 255, 255, 0);
    push_compute(0, 0);

    // size below one, zero width, oversized height, unused register slot
    set_config(0, 300, ONE - 1);
    reg_write(REG_SPARE_IDX, $urandom);
    push_compute(17, 200);
    set_config(0, 300, 0);
    push_compute(255, 255);

    // one-texel image at the largest size
    set_config(1, 1, 65535);
    push_compute(255, 255);
    push_compute(0, 0);

    // exactly one octave of size one over the full image
    set_config(DIM, DIM, ONE);
    push_req(CMD_LOAD, 255, 255, 255);
    push_compute(255, 255);
    push_compute(128, 1);

    // random phases, each with its own settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(pick_dim(), pick_dim(), pick_size());
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_REQS) begin
        r = $urandom_range(0, 9);
        if (r < 4) push_req(CMD_LOAD, pick_pos(), pick_pos(), $urandom_range(0, 255));
        else push_compute(pick_pos(), pick_pos());
      end
    end

    wait_quiet();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #150_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
